FILE: design/ptw_pkg.sv
package ptw_pkg;

  localparam int unsigned ENTRIES      = 512;
  localparam int unsigned IDX_W        = 9;
  localparam int unsigned OFF_W        = 12;
  localparam int unsigned VA_W         = 48;
  localparam int unsigned PA_W         = 52;
  localparam int unsigned LEAF_W       = 52;
  localparam int unsigned TABLES_DEF   = 16;

  typedef enum logic [1:0] {
    REQ_MAP       = 2'd0,
    REQ_UNMAP     = 2'd1,
    REQ_TRANSLATE = 2'd2,
    REQ_NONE      = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOFREE     = 2'd1,
    ST_NOTMAPPED  = 2'd2,
    ST_RSVD       = 2'd3
  } status_e;

endpackage

FILE: design/ptw_ram.sv
module ptw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ptw_init.sv
module ptw_init import ptw_pkg::*; #(
  parameter int unsigned DEPTH = TABLES_DEF * ENTRIES,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          busy_o,
  output logic [AW-1:0] addr_o
);

  logic          busy_q;
  logic [AW-1:0] addr_q;

  // one entry per cycle across every table store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      addr_q <= '0;
    end else if (busy_q) begin
      if (addr_q == AW'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end else begin
        addr_q <= addr_q + AW'(1);
      end
    end
  end

  assign busy_o = busy_q;
  assign addr_o = addr_q;

endmodule

FILE: design/four_level_page_table_engine.sv
// channel  dir  tdata                                               tuser
// s_axis   in   virt_addr[47:0] phys_addr[99:48] entry_flags[111:100]  req_type[1:0]
// m_axis   out  phys_out[51:0]                                      status[1:0] tlb_invalidate[2]
//
// map, unmap and translate walk the tables with one read per
// table level through the registered ram ports, the leaf read or write last
// a missing link ends the walk early, an unused request code goes straight to the result
// after reset the block runs a clearing pass over every table entry that
// loads the identity map of the first 2MB; s_axis_tready stays low until it ends
// one request at a time: the next transfer is taken once the result has gone out
module four_level_page_table_engine import ptw_pkg::*; #(
  parameter int unsigned TABLES_PER_LEVEL = TABLES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,  // virt_addr, phys_addr, entry_flags
  input  logic [1:0]   s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata,  // phys_out, zero pad
  output logic [2:0]   m_axis_tuser   // status, tlb_invalidate
);

  localparam int unsigned TW   = (TABLES_PER_LEVEL > 1) ? $clog2(TABLES_PER_LEVEL) : 1;
  localparam int unsigned LW   = TW + 1;
  localparam int unsigned POOL = TABLES_PER_LEVEL * ENTRIES;
  localparam int unsigned PAW  = $clog2(POOL);
  localparam int unsigned CW   = $clog2(TABLES_PER_LEVEL + 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_ROOT_RD, S_L3_CHK, S_L2_CHK, S_LEAF_CHK, S_LEAF_DO, S_RESP
  } state_e;

  state_e state_q, state_d;

  // request held for the walk
  logic [1:0]        req_q;
  logic [VA_W-1:0]   va_q;
  logic [PA_W-1:0]   pa_q;
  logic [OFF_W-1:0]  fl_q;
  logic [TW-1:0]     tbl_q, tbl_d;
  // tables are never released and taken lowest first, so a count is the used set
  logic [CW-1:0]     cnt3_q, cnt2_q, cnt1_q;
  logic [CW-1:0]     cnt3_d, cnt2_d, cnt1_d;
  logic [1:0]        st_q, st_d;
  logic [PA_W-1:0]   pout_q, pout_d;
  logic              inv_q, inv_d;

  // clearing pass
  logic              init_busy;
  logic [PAW-1:0]    init_addr;

  // ram ports
  logic              root_we, root_re, l3_we, l3_re, l2_we, l2_re, leaf_we, leaf_re;
  logic [IDX_W-1:0]  root_waddr, root_raddr;
  logic [PAW-1:0]    l3_waddr, l3_raddr, l2_waddr, l2_raddr, leaf_waddr, leaf_raddr;
  logic [LW-1:0]     root_wdata, l3_wdata, l2_wdata, root_rdata, l3_rdata, l2_rdata;
  logic [LEAF_W-1:0] leaf_wdata, leaf_rdata;

  // shared link check and allocation unit
  logic [LW-1:0]     cur_link;
  logic [CW-1:0]     cur_cnt;
  logic              present, full, link_ok, alloc;
  logic [TW-1:0]     next_tbl;

  // address helpers
  logic [IDX_W-1:0]  i4, i3, i2, i1;
  logic [TW+8:0]     par_cat, chl_cat;
  logic [PAW-1:0]    par_addr, chl_addr;
  logic [PA_W-1:0]   miss_out;

  assign i4 = va_q[47:39];
  assign i3 = va_q[38:30];
  assign i2 = va_q[29:21];
  assign i1 = va_q[20:12];
  assign miss_out = (req_q == REQ_TRANSLATE) ? PA_W'(va_q) : '0;

  ptw_init #(.DEPTH(POOL), .AW(PAW)) u_init (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (init_busy),
    .addr_o (init_addr)
  );

  always_comb begin
    unique case (state_q)
      S_L3_CHK: begin
        cur_link = root_rdata;
        cur_cnt  = cnt3_q;
      end
      S_L2_CHK: begin
        cur_link = l3_rdata;
        cur_cnt  = cnt2_q;
      end
      default: begin
        cur_link = l2_rdata;
        cur_cnt  = cnt1_q;
      end
    endcase
  end

  assign present  = cur_link[LW-1];
  assign full     = (cur_cnt == CW'(TABLES_PER_LEVEL));
  assign link_ok  = present || ((req_q == REQ_MAP) && !full);
  assign alloc    = !present && (req_q == REQ_MAP) && !full;
  assign next_tbl = present ? cur_link[TW-1:0] : cur_cnt[TW-1:0];

  // parent entry lives in the table picked at the level above
  assign par_cat  = {tbl_q, (state_q == S_L2_CHK) ? i3 : i2};
  assign par_addr = par_cat[PAW-1:0];
  // child read in the table just resolved
  always_comb begin
    unique case (state_q)
      S_L3_CHK: chl_cat = {next_tbl, i3};
      S_L2_CHK: chl_cat = {next_tbl, i2};
      S_LEAF_DO: chl_cat = {tbl_q, i1};
      default:  chl_cat = {next_tbl, i1};
    endcase
  end
  assign chl_addr = chl_cat[PAW-1:0];

  always_comb begin
    state_d    = state_q;
    tbl_d      = tbl_q;
    cnt3_d     = cnt3_q;
    cnt2_d     = cnt2_q;
    cnt1_d     = cnt1_q;
    st_d       = st_q;
    pout_d     = pout_q;
    inv_d      = inv_q;
    root_we    = 1'b0;
    root_waddr = i4;
    root_wdata = {1'b1, next_tbl};
    root_re    = 1'b0;
    root_raddr = i4;
    l3_we      = 1'b0;
    l3_waddr   = par_addr;
    l3_wdata   = {1'b1, next_tbl};
    l3_re      = 1'b0;
    l3_raddr   = chl_addr;
    l2_we      = 1'b0;
    l2_waddr   = par_addr;
    l2_wdata   = {1'b1, next_tbl};
    l2_re      = 1'b0;
    l2_raddr   = chl_addr;
    leaf_we    = 1'b0;
    leaf_waddr = chl_addr;
    leaf_wdata = {pa_q[PA_W-1:OFF_W], fl_q | OFF_W'(1)};
    leaf_re    = 1'b0;
    leaf_raddr = chl_addr;

    unique case (state_q)
      S_INIT: begin
        // reset image: root, level 3 and level 2 entry 0 link table 0
        root_we    = (32'(init_addr) < 32'(ENTRIES));
        root_waddr = init_addr[IDX_W-1:0];
        root_wdata = (init_addr == '0) ? {1'b1, TW'(0)} : '0;
        l3_we      = 1'b1;
        l3_waddr   = init_addr;
        l3_wdata   = root_wdata;
        l2_we      = 1'b1;
        l2_waddr   = init_addr;
        l2_wdata   = root_wdata;
        // leaf table 0 identity maps, present and writable
        leaf_we    = 1'b1;
        leaf_waddr = init_addr;
        leaf_wdata = (32'(init_addr) < 32'(ENTRIES)) ?
                     LEAF_W'({init_addr[IDX_W-1:0], 12'h003}) : '0;
        if (!init_busy) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == REQ_NONE) begin
            st_d    = ST_OK;
            pout_d  = '0;
            inv_d   = 1'b0;
            state_d = S_RESP;
          end else begin
            state_d = S_ROOT_RD;
          end
        end
      end
      S_ROOT_RD: begin
        root_re = 1'b1;
        state_d = S_L3_CHK;
      end
      S_L3_CHK, S_L2_CHK, S_LEAF_CHK: begin
        tbl_d = next_tbl;
        if (!link_ok) begin
          st_d    = (req_q == REQ_MAP) ? ST_NOFREE : ST_NOTMAPPED;
          pout_d  = miss_out;
          inv_d   = 1'b0;
          state_d = S_RESP;
        end else begin
          unique case (state_q)
            S_L3_CHK: begin
              root_we = alloc;
              l3_re   = 1'b1;
              if (alloc) cnt3_d = cnt3_q + CW'(1);
              state_d = S_L2_CHK;
            end
            S_L2_CHK: begin
              l3_we   = alloc;
              l2_re   = 1'b1;
              if (alloc) cnt2_d = cnt2_q + CW'(1);
              state_d = S_LEAF_CHK;
            end
            default: begin
              l2_we = alloc;
              if (alloc) cnt1_d = cnt1_q + CW'(1);
              if (req_q == REQ_MAP) begin
                leaf_we = 1'b1;
                st_d    = ST_OK;
                pout_d  = '0;
                inv_d   = 1'b1;
                state_d = S_RESP;
              end else begin
                leaf_re = 1'b1;
                state_d = S_LEAF_DO;
              end
            end
          endcase
        end
      end
      S_LEAF_DO: begin
        if (leaf_rdata[0]) begin
          st_d = ST_OK;
          if (req_q == REQ_UNMAP) begin
            leaf_we    = 1'b1;
            leaf_wdata = '0;
            pout_d     = '0;
            inv_d      = 1'b1;
          end else begin
            pout_d = {leaf_rdata[LEAF_W-1:OFF_W], va_q[OFF_W-1:0]};
            inv_d  = 1'b0;
          end
        end else begin
          st_d   = ST_NOTMAPPED;
          pout_d = miss_out;
          inv_d  = 1'b0;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt3_q  <= CW'(1);
      cnt2_q  <= CW'(1);
      cnt1_q  <= CW'(1);
    end else begin
      state_q <= state_d;
      cnt3_q  <= cnt3_d;
      cnt2_q  <= cnt2_d;
      cnt1_q  <= cnt1_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      req_q <= s_axis_tuser;
      va_q  <= s_axis_tdata[47:0];
      pa_q  <= s_axis_tdata[99:48];
      fl_q  <= s_axis_tdata[111:100];
    end
    tbl_q  <= tbl_d;
    st_q   <= st_d;
    pout_q <= pout_d;
    inv_q  <= inv_d;
  end

  ptw_ram #(.WIDTH(LW), .DEPTH(ENTRIES), .AW(IDX_W)) u_root (
    .clk_i (clk_i), .we_i (root_we), .waddr_i (root_waddr), .wdata_i (root_wdata),
    .re_i (root_re), .raddr_i (root_raddr), .rdata_o (root_rdata)
  );

  ptw_ram #(.WIDTH(LW), .DEPTH(POOL), .AW(PAW)) u_l3 (
    .clk_i (clk_i), .we_i (l3_we), .waddr_i (l3_waddr), .wdata_i (l3_wdata),
    .re_i (l3_re), .raddr_i (l3_raddr), .rdata_o (l3_rdata)
  );

  ptw_ram #(.WIDTH(LW), .DEPTH(POOL), .AW(PAW)) u_l2 (
    .clk_i (clk_i), .we_i (l2_we), .waddr_i (l2_waddr), .wdata_i (l2_wdata),
    .re_i (l2_re), .raddr_i (l2_raddr), .rdata_o (l2_rdata)
  );

  ptw_ram #(.WIDTH(LEAF_W), .DEPTH(POOL), .AW(PAW)) u_leaf (
    .clk_i (clk_i), .we_i (leaf_we), .waddr_i (leaf_waddr), .wdata_i (leaf_wdata),
    .re_i (leaf_re), .raddr_i (leaf_raddr), .rdata_o (leaf_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_RESP);
  assign m_axis_tdata  = {4'b0, pout_q};
  assign m_axis_tuser  = {inv_q, st_q};

endmodule
